// File: sv/crg_pkg.sv
// ----------------------------------------------------------------------------
// crg_pkg
// Shared widths, register map and types of the camera ray generator.
// ----------------------------------------------------------------------------
package crg_pkg;

  // fixed field widths
  localparam int COUNT_W    = 13;
  localparam int SIZE_W     = 16;
  localparam int COMP_W     = 16;
  localparam int BASIS_W    = 3 * COMP_W;
  localparam int INDEX_W    = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = BASIS_W;

  // normalized magnitudes have their top set bit here
  localparam int NORM_MSB = 30;
  localparam int NORM_W   = NORM_MSB + 1;

  // square sum and its root
  localparam int SQ_SUM_W = 64;
  localparam int ROOT_W   = SQ_SUM_W / 2;

  // register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_COLUMNS  = 3'd0,
    CFG_IMAGE_ROWS     = 3'd1,
    CFG_PLANE_WIDTH    = 3'd2,
    CFG_PLANE_HEIGHT   = 3'd3,
    CFG_FOCAL_DISTANCE = 3'd4,
    CFG_RIGHT_BASIS    = 3'd5,
    CFG_UP_BASIS       = 3'd6,
    CFG_FORWARD_BASIS  = 3'd7
  } cfg_addr_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [COUNT_W-1:0] image_columns;
    logic [COUNT_W-1:0] image_rows;
    logic [SIZE_W-1:0]  plane_width;
    logic [SIZE_W-1:0]  plane_height;
    logic [SIZE_W-1:0]  focal_distance;
    logic [BASIS_W-1:0] right_basis;
    logic [BASIS_W-1:0] up_basis;
    logic [BASIS_W-1:0] forward_basis;
  } cfg_t;

  // per-item status that rides along to the divider
  typedef struct packed {
    logic [2:0] neg;
    logic       zero;
  } flags_t;

  // one signed component of a packed basis vector, x in the low bits
  function automatic logic signed [COMP_W-1:0] basis_part(logic [BASIS_W-1:0] b, int i);
    return $signed(b[i*COMP_W +: COMP_W]);
  endfunction

endpackage

// File: sv/camera_ray_generator.sv
// ----------------------------------------------------------------------------
// camera_ray_generator
// Pinhole camera ray generator: unit direction through a pixel centre.
// ----------------------------------------------------------------------------
// Takes one pixel (column, row) per cycle and returns the unit ray direction
// through that pixel's centre as three signed fixed-point components with
// FRAC_BITS fraction bits, saturated to 16 bits, plus the linear pixel index.
// The pipeline accepts an item every cycle while the output is free or being
// taken. The offset divider has max(COORD_BITS + 2, 15) + 16 stages, and the
// pipeline length is set by the two bit-per-stage dividers and the 32-stage
// square root. Configuration registers are read live by the pipeline and must
// only be written while no item is in flight.
// ----------------------------------------------------------------------------
module camera_ray_generator #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 14,
  localparam int S_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int M_DATA_W  = 3 * crg_pkg::COMP_W + crg_pkg::INDEX_W
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_wen,
  input  logic [crg_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [crg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // pixel items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [S_DATA_W-1:0]            s_tdata,  // column, row, zero fill
  // ray items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [M_DATA_W-1:0]            m_tdata   // ray_x, ray_y, ray_z, pixel_index
);

  localparam int CW      = crg_pkg::COMP_W;
  localparam int IW      = crg_pkg::INDEX_W;
  localparam int NORM_W  = crg_pkg::NORM_W;
  localparam int NW      = (COORD_BITS + 2 > crg_pkg::COUNT_W + 2) ?
                           COORD_BITS + 2 : crg_pkg::COUNT_W + 2;
  localparam int OFS_W   = NW + crg_pkg::SIZE_W + 1;
  localparam int MAG_W   = OFS_W + CW + 2;
  localparam int PIX_W   = (COORD_BITS + crg_pkg::COUNT_W + 1 > IW) ?
                           COORD_BITS + crg_pkg::COUNT_W + 1 : IW;
  localparam int NRM_TAG_W = IW + 3;
  localparam int ISQ_TAG_W = IW + 3 + 1 + 3 * NORM_W;

  // configuration registers
  crg_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{image_columns:  crg_pkg::COUNT_W'(640),
               image_rows:     crg_pkg::COUNT_W'(480),
               plane_width:    crg_pkg::SIZE_W'(4096),
               plane_height:   crg_pkg::SIZE_W'(4096),
               focal_distance: crg_pkg::SIZE_W'(4096),
               right_basis:    '0,
               up_basis:       '0,
               forward_basis:  '0};
    end else if (cfg_wen) begin
      unique case (crg_pkg::cfg_addr_t'(cfg_index))
        crg_pkg::CFG_IMAGE_COLUMNS:  cfg.image_columns  <= cfg_wdata[crg_pkg::COUNT_W-1:0];
        crg_pkg::CFG_IMAGE_ROWS:     cfg.image_rows     <= cfg_wdata[crg_pkg::COUNT_W-1:0];
        crg_pkg::CFG_PLANE_WIDTH:    cfg.plane_width    <= cfg_wdata[crg_pkg::SIZE_W-1:0];
        crg_pkg::CFG_PLANE_HEIGHT:   cfg.plane_height   <= cfg_wdata[crg_pkg::SIZE_W-1:0];
        crg_pkg::CFG_FOCAL_DISTANCE: cfg.focal_distance <= cfg_wdata[crg_pkg::SIZE_W-1:0];
        crg_pkg::CFG_RIGHT_BASIS:    cfg.right_basis    <= cfg_wdata;
        crg_pkg::CFG_UP_BASIS:       cfg.up_basis       <= cfg_wdata;
        crg_pkg::CFG_FORWARD_BASIS:  cfg.forward_basis  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // whole pipeline moves while the output register is free or being taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input fields and linear pixel index
  logic [COORD_BITS-1:0] column, row;
  logic [PIX_W-1:0]      pix_full;
  logic [IW-1:0]         pix;

  assign column   = s_tdata[COORD_BITS-1:0];
  assign row      = s_tdata[2*COORD_BITS-1:COORD_BITS];
  assign pix_full = PIX_W'(row) * PIX_W'(cfg.image_columns) + PIX_W'(column);
  assign pix      = pix_full[IW-1:0];

  // plane offsets
  logic [COORD_BITS-1:0]       ofs_coord [2];
  logic [crg_pkg::COUNT_W-1:0] ofs_count [2];
  logic [crg_pkg::SIZE_W-1:0]  ofs_size  [2];
  logic                        ofs_valid;
  logic signed [OFS_W-1:0]     ofs [2];
  logic [IW-1:0]               ofs_tag;

  assign ofs_coord[0] = column;
  assign ofs_coord[1] = row;
  assign ofs_count[0] = cfg.image_columns;
  assign ofs_count[1] = cfg.image_rows;
  assign ofs_size[0]  = cfg.plane_width;
  assign ofs_size[1]  = cfg.plane_height;

  crg_offset #(
    .COORD_BITS (COORD_BITS),
    .TAG_W      (IW)
  ) u_offset (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .coord      (ofs_coord),
    .count      (ofs_count),
    .size       (ofs_size),
    .in_tag     (pix),
    .out_valid  (ofs_valid),
    .out_offset (ofs),
    .out_tag    (ofs_tag)
  );

  // direction from the basis
  logic             prj_valid;
  logic [MAG_W-1:0] prj_mag [3];
  logic [2:0]       prj_neg;
  logic [IW-1:0]    prj_tag;

  crg_project #(
    .OFS_W     (OFS_W),
    .TAG_W     (IW)
  ) u_project (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ofs_valid),
    .in_ox     (ofs[0]),
    .in_oy     (ofs[1]),
    .cfg       (cfg),
    .in_tag    (ofs_tag),
    .out_valid (prj_valid),
    .out_mag   (prj_mag),
    .out_neg   (prj_neg),
    .out_tag   (prj_tag)
  );

  // normalization and square sum
  logic                         nrm_valid;
  logic [NORM_W-1:0]            nrm_norm [3];
  logic [crg_pkg::SQ_SUM_W-1:0] nrm_sum;
  logic                         nrm_zero;
  logic [NRM_TAG_W-1:0]         nrm_tag;

  crg_normalize #(
    .MAG_W     (MAG_W),
    .TAG_W     (NRM_TAG_W)
  ) u_normalize (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prj_valid),
    .in_mag    (prj_mag),
    .in_tag    ({prj_tag, prj_neg}),
    .out_valid (nrm_valid),
    .out_norm  (nrm_norm),
    .out_sum   (nrm_sum),
    .out_zero  (nrm_zero),
    .out_tag   (nrm_tag)
  );

  // vector length
  logic                       isq_valid;
  logic [crg_pkg::ROOT_W-1:0] isq_root;
  logic [ISQ_TAG_W-1:0]       isq_tag;

  crg_isqrt #(
    .TAG_W       (ISQ_TAG_W)
  ) u_isqrt (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (nrm_valid),
    .in_radicand (nrm_sum),
    .in_tag      ({nrm_tag, nrm_zero, nrm_norm[2], nrm_norm[1], nrm_norm[0]}),
    .out_valid   (isq_valid),
    .out_root    (isq_root),
    .out_tag     (isq_tag)
  );

  // unpack what rode along with the root
  logic [NORM_W-1:0] scl_norm [3];
  crg_pkg::flags_t   scl_flags;
  logic [IW-1:0]     scl_pix;

  assign scl_norm[0]    = isq_tag[0 +: NORM_W];
  assign scl_norm[1]    = isq_tag[NORM_W +: NORM_W];
  assign scl_norm[2]    = isq_tag[2*NORM_W +: NORM_W];
  assign scl_flags.zero = isq_tag[3*NORM_W];
  assign scl_flags.neg  = isq_tag[3*NORM_W+1 +: 3];
  assign scl_pix        = isq_tag[3*NORM_W+4 +: IW];

  // unit components
  logic signed [CW-1:0] ray [3];
  logic [IW-1:0]        out_pix;

  crg_scale #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (IW)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (isq_valid),
    .in_root   (isq_root),
    .in_norm   (scl_norm),
    .in_flags  (scl_flags),
    .in_tag    (scl_pix),
    .out_valid (m_tvalid),
    .out_comp  (ray),
    .out_tag   (out_pix)
  );

  assign m_tdata = {out_pix, ray[2], ray[1], ray[0]};

  // a held result blocks new items
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("item accepted while the output is stalled");

  // a stalled result is not replaced
  a_stall_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("stalled result dropped");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !m_tvalid)
    else $error("result present right after reset");

endmodule

// File: sv/crg_offset.sv
// ----------------------------------------------------------------------------
// crg_offset
// Image plane offsets of the pixel centre for both axes: signed scale by the
// plane size, then a bit-per-stage divider by twice the pixel count.
// ----------------------------------------------------------------------------
module crg_offset #(
  parameter int COORD_BITS = 12,
  parameter int TAG_W      = 24,
  localparam int NW     = (COORD_BITS + 2 > crg_pkg::COUNT_W + 2) ?
                          COORD_BITS + 2 : crg_pkg::COUNT_W + 2,
  localparam int OFS_W  = NW + crg_pkg::SIZE_W + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [COORD_BITS-1:0]          coord [2],
  input  logic [crg_pkg::COUNT_W-1:0]    count [2],
  input  logic [crg_pkg::SIZE_W-1:0]     size  [2],
  input  logic [TAG_W-1:0]               in_tag,
  output logic                           out_valid,
  output logic signed [OFS_W-1:0]        out_offset [2],
  output logic [TAG_W-1:0]               out_tag
);

  localparam int PROD_W = NW + crg_pkg::SIZE_W + 1;
  localparam int DVD_W  = NW + crg_pkg::SIZE_W;
  localparam int QW     = DVD_W;
  localparam int DVS_W  = crg_pkg::COUNT_W + 1;
  localparam int LAT    = QW + 4;

  logic [LAT-1:0]   vpipe;
  logic [TAG_W-1:0] tpipe [LAT];

  // valid and tag line
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tpipe[0] <= in_tag;
      for (int i = 1; i < LAT; i++) tpipe[i] <= tpipe[i-1];
    end
  end

  assign out_valid = vpipe[LAT-1];
  assign out_tag   = tpipe[LAT-1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [crg_pkg::COUNT_W-1:0] w_c;
    logic signed [NW-1:0]        n_c;
    logic signed [NW-1:0]        n0;
    logic [crg_pkg::COUNT_W-1:0] w0, w1;
    logic [crg_pkg::SIZE_W-1:0]  s0;
    logic signed [PROD_W-1:0]    num1;
    logic signed [PROD_W-1:0]    w1_s;
    logic signed [PROD_W-1:0]    adj_c;
    logic [DVD_W-1:0]            dnum [QW+1];
    logic [DVS_W-1:0]            drem [QW+1];
    logic [QW-1:0]               dquo [QW+1];
    logic [DVS_W-1:0]            ddvs [QW+1];
    logic                        dneg [QW+1];
    logic signed [OFS_W-1:0]     ofs;

    // centre offset numerator 2*coord + 1 - count, a zero count taken as one
    always_comb begin
      w_c = (count[l] == '0) ? crg_pkg::COUNT_W'(1) : count[l];
      n_c = $signed(NW'({coord[l], 1'b1})) - $signed(NW'(w_c));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n0 <= n_c;
        w0 <= w_c;
        s0 <= size[l];
      end
    end

    // scale by the plane size
    always_ff @(posedge clk) begin
      if (en) begin
        num1 <= n0 * $signed({1'b0, s0});
        w1   <= w0;
      end
    end

    // magnitude plus half the divisor, for rounding away from zero
    always_comb begin
      w1_s  = $signed(PROD_W'(w1));
      adj_c = num1[PROD_W-1] ? (w1_s - num1) : (num1 + w1_s);
    end

    logic [DVD_W-1:0]  dvd2;
    logic [DVS_W-1:0]  dvs2;
    logic              neg2;

    always_ff @(posedge clk) begin
      if (en) begin
        dvd2 <= adj_c[DVD_W-1:0];
        dvs2 <= {w1, 1'b0};
        neg2 <= num1[PROD_W-1];
      end
    end

    assign dnum[0] = dvd2;
    assign drem[0] = '0;
    assign dquo[0] = '0;
    assign ddvs[0] = dvs2;
    assign dneg[0] = neg2;

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DVS_W:0] shifted;
      logic           ge;

      always_comb begin
        shifted = {drem[k], dnum[k][DVD_W-1]};
        ge      = shifted >= {1'b0, ddvs[k]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          drem[k+1] <= ge ? DVS_W'(shifted - {1'b0, ddvs[k]}) : DVS_W'(shifted);
          dquo[k+1] <= {dquo[k][QW-2:0], ge};
          dnum[k+1] <= dnum[k] << 1;
          ddvs[k+1] <= ddvs[k];
          dneg[k+1] <= dneg[k];
        end
      end
    end

    // apply the sign
    always_ff @(posedge clk) begin
      if (en) begin
        ofs <= dneg[QW] ? -$signed({1'b0, dquo[QW]}) : $signed({1'b0, dquo[QW]});
      end
    end

    assign out_offset[l] = ofs;
  end

endmodule

// File: sv/crg_project.sv
// ----------------------------------------------------------------------------
// crg_project
// Direction from the camera basis: offsets times right and up plus focal
// length times forward, split into magnitude and sign per component.
// ----------------------------------------------------------------------------
module crg_project #(
  parameter int OFS_W = 32,
  parameter int TAG_W = 24,
  localparam int MAG_W = OFS_W + crg_pkg::COMP_W + 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [OFS_W-1:0] in_ox,
  input  logic signed [OFS_W-1:0] in_oy,
  input  crg_pkg::cfg_t           cfg,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_valid,
  output logic [MAG_W-1:0]        out_mag [3],
  output logic [2:0]              out_neg,
  output logic [TAG_W-1:0]        out_tag
);

  localparam int PW  = OFS_W + crg_pkg::COMP_W;
  localparam int FW  = crg_pkg::SIZE_W + 1 + crg_pkg::COMP_W;
  localparam int D_W = MAG_W;
  localparam int LAT = 3;

  logic [LAT-1:0]   vpipe;
  logic [TAG_W-1:0] tpipe [LAT];

  // valid and tag line
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tpipe[0] <= in_tag;
      for (int i = 1; i < LAT; i++) tpipe[i] <= tpipe[i-1];
    end
  end

  assign out_valid = vpipe[LAT-1];
  assign out_tag   = tpipe[LAT-1];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic signed [PW-1:0]  pr, pu;
    logic signed [FW-1:0]  pf;
    logic signed [D_W-1:0] d2;
    logic [MAG_W-1:0]      mag3;
    logic                  neg3;

    // three products per component
    always_ff @(posedge clk) begin
      if (en) begin
        pr <= in_ox * crg_pkg::basis_part(cfg.right_basis, c);
        pu <= in_oy * crg_pkg::basis_part(cfg.up_basis, c);
        pf <= $signed({1'b0, cfg.focal_distance}) *
              crg_pkg::basis_part(cfg.forward_basis, c);
      end
    end

    // exact sum
    always_ff @(posedge clk) begin
      if (en) begin
        d2 <= D_W'(pr) + D_W'(pu) + D_W'(pf);
      end
    end

    // magnitude and sign
    always_ff @(posedge clk) begin
      if (en) begin
        mag3 <= d2[D_W-1] ? MAG_W'(-d2) : MAG_W'(d2);
        neg3 <= d2[D_W-1];
      end
    end

    assign out_mag[c] = mag3;
    assign out_neg[c] = neg3;
  end

endmodule

// File: sv/crg_normalize.sv
// ----------------------------------------------------------------------------
// crg_normalize
// Common shift so the largest magnitude has its top bit at bit 30, then the
// sum of squares of the shifted magnitudes.
// ----------------------------------------------------------------------------
module crg_normalize #(
  parameter int MAG_W = 50,
  parameter int TAG_W = 27
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [MAG_W-1:0]                 in_mag [3],
  input  logic [TAG_W-1:0]                 in_tag,
  output logic                             out_valid,
  output logic [crg_pkg::NORM_W-1:0]       out_norm [3],
  output logic [crg_pkg::SQ_SUM_W-1:0]     out_sum,
  output logic                             out_zero,
  output logic [TAG_W-1:0]                 out_tag
);

  localparam int NORM_W = crg_pkg::NORM_W;
  localparam int G      = (MAG_W + 7) / 8;
  localparam int POS_W  = $clog2(G * 8);
  localparam int LAT    = 5;

  logic [LAT-1:0]   vpipe;
  logic [TAG_W-1:0] tpipe [LAT];

  // valid and tag line
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tpipe[0] <= in_tag;
      for (int i = 1; i < LAT; i++) tpipe[i] <= tpipe[i-1];
    end
  end

  assign out_valid = vpipe[LAT-1];
  assign out_tag   = tpipe[LAT-1];

  function automatic logic [2:0] msb8(logic [7:0] v);
    logic [2:0] r;
    r = '0;
    for (int b = 0; b < 8; b++) if (v[b]) r = 3'(b);
    return r;
  endfunction

  // leading one per byte of the or of all magnitudes
  logic [G*8-1:0]    orv;
  logic [MAG_W-1:0]  m1 [3];
  logic [G-1:0]      gnz1;
  logic [2:0]        gpos1 [G];

  assign orv = (G*8)'(in_mag[0] | in_mag[1] | in_mag[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) m1[c] <= in_mag[c];
      for (int g = 0; g < G; g++) begin
        gnz1[g]  <= |orv[g*8 +: 8];
        gpos1[g] <= msb8(orv[g*8 +: 8]);
      end
    end
  end

  // highest nonzero byte gives the leading bit position
  logic [POS_W-1:0] pos_c, pos2;
  logic [MAG_W-1:0] m2 [3];
  logic             any2;

  always_comb begin
    pos_c = '0;
    for (int g = 0; g < G; g++) begin
      if (gnz1[g]) pos_c = POS_W'(g * 8) | POS_W'(gpos1[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) m2[c] <= m1[c];
      pos2 <= pos_c;
      any2 <= |gnz1;
    end
  end

  // shift all three together, truncating on the right
  logic [NORM_W-1:0] n3 [3];
  logic              any3;
  logic [NORM_W-1:0] n_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (pos2 > POS_W'(crg_pkg::NORM_MSB)) begin
        n_c[c] = NORM_W'(m2[c] >> (pos2 - POS_W'(crg_pkg::NORM_MSB)));
      end else begin
        n_c[c] = NORM_W'(m2[c]) << (POS_W'(crg_pkg::NORM_MSB) - pos2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) n3[c] <= n_c[c];
      any3 <= any2;
    end
  end

  // squares
  logic [NORM_W-1:0]   n4 [3];
  logic [2*NORM_W-1:0] sq4 [3];
  logic                any4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        n4[c]  <= n3[c];
        sq4[c] <= n3[c] * n3[c];
      end
      any4 <= any3;
    end
  end

  // sum of squares
  logic [NORM_W-1:0]            n5 [3];
  logic [crg_pkg::SQ_SUM_W-1:0] sum5;
  logic                         any5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) n5[c] <= n4[c];
      sum5 <= crg_pkg::SQ_SUM_W'(sq4[0]) + crg_pkg::SQ_SUM_W'(sq4[1]) +
              crg_pkg::SQ_SUM_W'(sq4[2]);
      any5 <= any4;
    end
  end

  assign out_norm = n5;
  assign out_sum  = sum5;
  assign out_zero = !any5;

  // a nonzero direction always comes out with its top bit in place
  logic [NORM_W-1:0] norm_or;
  assign norm_or = n5[0] | n5[1] | n5[2];

  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_zero |-> norm_or[crg_pkg::NORM_MSB])
    else $error("normalized direction lost its leading bit");

endmodule

// File: sv/crg_isqrt.sv
// ----------------------------------------------------------------------------
// crg_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module crg_isqrt #(
  parameter int TAG_W = 121
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [crg_pkg::SQ_SUM_W-1:0]  in_radicand,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_valid,
  output logic [crg_pkg::ROOT_W-1:0]    out_root,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int RW    = crg_pkg::ROOT_W;
  localparam int SW    = crg_pkg::SQ_SUM_W;
  localparam int REM_W = RW + 2;
  localparam int LAT   = RW;

  logic [LAT-1:0]   vpipe;
  logic [TAG_W-1:0] tpipe [LAT];

  // valid and tag line
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tpipe[0] <= in_tag;
      for (int i = 1; i < LAT; i++) tpipe[i] <= tpipe[i-1];
    end
  end

  assign out_valid = vpipe[LAT-1];
  assign out_tag   = tpipe[LAT-1];

  logic [SW-1:0]    rad  [RW+1];
  logic [REM_W-1:0] rem  [RW+1];
  logic [RW-1:0]    root [RW+1];

  assign rad[0]  = in_radicand;
  assign rem[0]  = '0;
  assign root[0] = '0;

  // two radicand bits in, one root bit out per stage
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {rem[k], rad[k][SW-1 -: 2]};
      trial = (REM_W+2)'({root[k], 2'b01});
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        root[k+1] <= {root[k][RW-2:0], ge};
        rad[k+1]  <= rad[k] << 2;
      end
    end
  end

  assign out_root = root[RW];

endmodule

// File: sv/crg_scale.sv
// ----------------------------------------------------------------------------
// crg_scale
// Divides each normalized magnitude by the root with rounding, one quotient
// bit per stage, then signs and saturates to the output format.
// ----------------------------------------------------------------------------
module crg_scale #(
  parameter int FRAC_BITS = 14,
  parameter int TAG_W     = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [crg_pkg::ROOT_W-1:0]        in_root,
  input  logic [crg_pkg::NORM_W-1:0]        in_norm [3],
  input  crg_pkg::flags_t                   in_flags,
  input  logic [TAG_W-1:0]                  in_tag,
  output logic                              out_valid,
  output logic signed [crg_pkg::COMP_W-1:0] out_comp [3],
  output logic [TAG_W-1:0]                  out_tag
);

  localparam int RW    = crg_pkg::ROOT_W;
  localparam int CW    = crg_pkg::COMP_W;
  localparam int QB    = FRAC_BITS + 2;
  localparam int NUM_W = crg_pkg::NORM_W + FRAC_BITS + 1;
  localparam int CMP_W = (QB > CW + 1) ? QB : CW + 1;
  localparam int LAT   = QB + 2;
  localparam logic [CMP_W-1:0] POS_LIMIT = CMP_W'((1 << (CW - 1)) - 1);
  localparam logic [CMP_W-1:0] NEG_LIMIT = CMP_W'(1 << (CW - 1));

  logic [LAT-1:0]        vpipe;
  logic [TAG_W-1:0]      tpipe [LAT];
  crg_pkg::flags_t       fpipe [LAT];

  // valid, tag and flag line
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tpipe[0] <= in_tag;
      fpipe[0] <= in_flags;
      for (int i = 1; i < LAT; i++) begin
        tpipe[i] <= tpipe[i-1];
        fpipe[i] <= fpipe[i-1];
      end
    end
  end

  assign out_valid = vpipe[LAT-1];
  assign out_tag   = tpipe[LAT-1];

  // divisor travels beside the quotient stages
  logic [RW-1:0] dvs [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dvs[0] <= in_root;
      for (int k = 0; k < QB; k++) dvs[k+1] <= dvs[k];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic [NUM_W-1:0]     num0;
    logic [RW-1:0]        drem [QB+1];
    logic [QB-1:0]        dlo  [QB+1];
    logic [QB-1:0]        dquo [QB+1];
    logic [CMP_W-1:0]     qx;
    logic signed [CW-1:0] comp;

    // scaled magnitude plus half the root
    always_ff @(posedge clk) begin
      if (en) begin
        num0 <= (NUM_W'(in_norm[c]) << FRAC_BITS) + NUM_W'(in_root >> 1);
      end
    end

    // upper bits already sit below the divisor
    assign drem[0] = RW'(num0 >> QB);
    assign dlo[0]  = num0[QB-1:0];
    assign dquo[0] = '0;

    for (genvar k = 0; k < QB; k++) begin : g_div
      logic [RW:0] shifted;
      logic        ge;

      always_comb begin
        shifted = {drem[k], dlo[k][QB-1]};
        ge      = shifted >= {1'b0, dvs[k]};
      end

      always_ff @(posedge clk) begin
        if (en) begin
          drem[k+1] <= ge ? RW'(shifted - {1'b0, dvs[k]}) : RW'(shifted);
          dlo[k+1]  <= dlo[k] << 1;
          dquo[k+1] <= {dquo[k][QB-2:0], ge};
        end
      end
    end

    // sign and saturate, zero direction gives zero
    assign qx = CMP_W'(dquo[QB]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (fpipe[LAT-2].zero) begin
          comp <= '0;
        end else if (fpipe[LAT-2].neg[c]) begin
          comp <= (qx > NEG_LIMIT) ? $signed(CW'(NEG_LIMIT)) :
                                     $signed(CW'(CMP_W'(0) - qx));
        end else begin
          comp <= (qx > POS_LIMIT) ? $signed(CW'(POS_LIMIT)) : $signed(CW'(qx));
        end
      end
    end

    assign out_comp[c] = comp;
  end

endmodule
